[hw/rtl/nsf_pkg.sv]
// Shared types, character codes and helpers for the NMEA sentence framer.
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

    localparam logic [7:0] C_MAX_PAYLOAD = 8'd128;
    localparam logic [5:0] C_MAX_FIELDS  = 6'd32;

    localparam logic [7:0] C_CH_DOLLAR = 8'h24;
    localparam logic [7:0] C_CH_BANG   = 8'h21;
    localparam logic [7:0] C_CH_STAR   = 8'h2A;
    localparam logic [7:0] C_CH_COMMA  = 8'h2C;
    localparam logic [7:0] C_CH_CR     = 8'h0D;
    localparam logic [7:0] C_CH_LF     = 8'h0A;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_BODY = 2'd1,
        PH_HEX1 = 2'd2,
        PH_HEX2 = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_INCOMPLETE = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_CSUM_ERR   = 3'd2,
        ST_FRAMING    = 3'd3,
        ST_OVERFLOW   = 3'd4
    } t_status;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] running_sum;
        logic [7:0] expected_sum;
        logic [7:0] payload_count;
        logic [5:0] token_count;
        logic [7:0] token_begin;
    } t_state;

    typedef struct packed {
        t_status    status;
        logic       payload_valid;
        logic [7:0] payload_char;
        logic [5:0] field_index;
        logic       field_closed;
        logic [7:0] field_start;
        logic [7:0] field_length;
        logic [5:0] token_total;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // Decodes one ASCII hex digit, either letter case.
    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.nib = 4'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            h.nib = 4'(ch - 8'h37);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            h.nib = 4'(ch - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/nmea_sentence_framer_unit.sv]
// Top level of the streaming NMEA 0183 sentence framer.
`timescale 1ns / 1ps
`default_nettype none

// The framer takes one received character per input transaction and returns exactly
// one result transaction for it, carrying the sentence status, the payload character
// if the character was stored, a descriptor of any field that a comma or asterisk
// closed, and the running and received checksums. A '$' or '!' starts a new sentence
// at any time. The sentence state registers and the result register are both loaded
// in the cycle the character is accepted, so its result appears in the next cycle;
// a new character can be accepted every cycle. The input side stays ready while a
// result waits, as long as that result is taken in the same cycle; only a result left
// untaken stalls the input. There is no configuration and no start-up delay after
// reset.
module nmea_sentence_framer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_status,
    output logic            o_payload_valid,
    output logic [7:0]      o_payload_char,
    output logic [5:0]      o_field_index,
    output logic            o_field_closed,
    output logic [7:0]      o_field_start,
    output logic [7:0]      o_field_length,
    output logic [5:0]      o_token_total,
    output logic [7:0]      o_computed_sum,
    output logic [7:0]      o_received_sum
);

    nsf_pkg::t_state  r_state;
    nsf_pkg::t_state  n_state;
    nsf_pkg::t_result r_out;
    nsf_pkg::t_result n_out;
    logic             r_out_valid;
    logic             w_in_accept;

    // The result register frees up in the same cycle its contents are taken.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    nsf_step u_step (
        .i_state  (r_state),
        .i_char   (i_char_in),
        .o_next   (n_state),
        .o_result (n_out)
    );

    // Sentence state advances once per accepted character. The wait phase encodes as
    // zero, so clearing the whole state also puts the framer in the wait phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_char  = r_out.payload_char;
    assign o_field_index   = r_out.field_index;
    assign o_field_closed  = r_out.field_closed;
    assign o_field_start   = r_out.field_start;
    assign o_field_length  = r_out.field_length;
    assign o_token_total   = r_out.token_total;
    assign o_computed_sum  = r_out.computed_sum;
    assign o_received_sum  = r_out.received_sum;

    // A closed field is always the token just before the new token total.
    a_closed_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_closed) |-> ((o_field_index + 6'd1) == o_token_total))
        else $error("closed field index does not precede token total");

    // A stored payload character never coincides with a field close or a final status.
    a_payload_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_valid) |->
            (!o_field_closed && o_status == nsf_pkg::ST_INCOMPLETE))
        else $error("payload character reported together with close or status");

    // A complete sentence means the two checksums agree.
    a_complete_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == nsf_pkg::ST_COMPLETE) |->
            (o_computed_sum == o_received_sum))
        else $error("complete status with mismatching checksums");

    // Every accepted character produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_out_valid)
        else $error("accepted character produced no result");

endmodule

`default_nettype wire

[hw/rtl/nsf_step.sv]
// Combinational per-character step of the framer: next sentence state and result.
`timescale 1ns / 1ps
`default_nettype none

module nsf_step (
    input  wire nsf_pkg::t_state  i_state,
    input  wire logic [7:0]       i_char,
    output nsf_pkg::t_state       o_next,
    output nsf_pkg::t_result      o_result
);

    logic          w_start;
    logic          w_crlf;
    logic          w_delim;
    logic          w_comma;
    logic          w_tok_over;
    logic          w_pay_over;
    nsf_pkg::t_hex w_hex;
    nsf_pkg::t_phase n_phase;

    assign w_start    = (i_char == nsf_pkg::C_CH_DOLLAR) || (i_char == nsf_pkg::C_CH_BANG);
    assign w_crlf     = (i_char == nsf_pkg::C_CH_CR) || (i_char == nsf_pkg::C_CH_LF);
    assign w_comma    = (i_char == nsf_pkg::C_CH_COMMA);
    assign w_delim    = w_comma || (i_char == nsf_pkg::C_CH_STAR);
    assign w_tok_over = (i_state.token_count > nsf_pkg::C_MAX_FIELDS);
    assign w_pay_over = (i_state.payload_count >= nsf_pkg::C_MAX_PAYLOAD);
    assign w_hex      = nsf_pkg::hex_decode(i_char);

    // Next phase.
    always_comb begin
        n_phase = i_state.phase;
        if (w_start) begin
            n_phase = nsf_pkg::PH_BODY;
        end else begin
            unique case (i_state.phase)
                nsf_pkg::PH_WAIT: n_phase = nsf_pkg::PH_WAIT;
                nsf_pkg::PH_BODY: begin
                    if (w_crlf) begin
                        n_phase = nsf_pkg::PH_WAIT;
                    end else if (w_delim) begin
                        if (w_tok_over) begin
                            n_phase = nsf_pkg::PH_WAIT;
                        end else if (!w_comma) begin
                            n_phase = nsf_pkg::PH_HEX1;
                        end
                    end else if (w_pay_over) begin
                        n_phase = nsf_pkg::PH_WAIT;
                    end
                end
                nsf_pkg::PH_HEX1: n_phase = w_hex.ok ? nsf_pkg::PH_HEX2 : nsf_pkg::PH_WAIT;
                nsf_pkg::PH_HEX2: n_phase = nsf_pkg::PH_WAIT;
                default:          n_phase = nsf_pkg::PH_WAIT;
            endcase
        end
    end

    // Sentence data and the result of this character.
    always_comb begin
        o_next            = i_state;
        o_result          = '0;
        o_result.status   = nsf_pkg::ST_INCOMPLETE;
        if (w_start) begin
            o_next = '0;
        end else begin
            unique case (i_state.phase)
                nsf_pkg::PH_WAIT: begin
                end
                nsf_pkg::PH_BODY: begin
                    if (w_crlf) begin
                        o_result.status = nsf_pkg::ST_FRAMING;
                    end else if (w_delim) begin
                        if (w_comma) begin
                            o_next.running_sum = i_state.running_sum ^ i_char;
                        end
                        if (w_tok_over) begin
                            o_result.status = nsf_pkg::ST_OVERFLOW;
                        end else begin
                            o_result.field_closed = 1'b1;
                            o_result.field_index  = i_state.token_count;
                            o_result.field_start  = i_state.token_begin;
                            o_result.field_length = i_state.payload_count
                                                  - i_state.token_begin;
                            o_next.token_count    = i_state.token_count + 6'd1;
                            if (w_comma) begin
                                o_next.token_begin = i_state.payload_count;
                            end
                        end
                    end else if (w_pay_over) begin
                        o_result.status = nsf_pkg::ST_OVERFLOW;
                    end else begin
                        o_next.running_sum     = i_state.running_sum ^ i_char;
                        o_next.payload_count   = i_state.payload_count + 8'd1;
                        o_result.payload_valid = 1'b1;
                        o_result.payload_char  = i_char;
                    end
                end
                nsf_pkg::PH_HEX1: begin
                    if (w_hex.ok) begin
                        o_next.expected_sum = {w_hex.nib, 4'd0};
                    end else begin
                        o_result.status = nsf_pkg::ST_FRAMING;
                    end
                end
                nsf_pkg::PH_HEX2: begin
                    if (w_hex.ok) begin
                        o_next.expected_sum = {i_state.expected_sum[7:4], w_hex.nib};
                        o_result.status = (i_state.running_sum ==
                                           {i_state.expected_sum[7:4], w_hex.nib})
                                        ? nsf_pkg::ST_COMPLETE : nsf_pkg::ST_CSUM_ERR;
                    end else begin
                        o_result.status = nsf_pkg::ST_FRAMING;
                    end
                end
                default: begin
                end
            endcase
        end
        o_next.phase = n_phase;
        if (!o_result.field_closed) begin
            o_result.field_index = o_next.token_count;
        end
        o_result.token_total  = o_next.token_count;
        o_result.computed_sum = o_next.running_sum;
        o_result.received_sum = o_next.expected_sum;
    end

endmodule

`default_nettype wire
